// ----- hdl/rawdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rawdc_pkg
// Constants and types for the rank assignment block with duplicate check.
// ----------------------------------------------------------------------------
package rawdc_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 6;

	typedef enum logic [4:0] {
		ST_LOAD     = 5'b00001,
		ST_SCAN     = 5'b00010,
		ST_DRAIN    = 5'b00100,
		ST_EMIT     = 5'b01000,
		ST_EMIT_DUP = 5'b10000
	} state_t;

endpackage

// ----- hdl/rank_assign_with_duplicate_check.sv -----
// ----------------------------------------------------------------------------
// rank_assign_with_duplicate_check
// Loads a list of signed values, then emits the rank of each value in load
// order, or a single duplicate result if two values are equal.
// ----------------------------------------------------------------------------
// Values are loaded one item per cycle into a 64-entry value memory; values
// beyond the capacity are dropped and flagged as overflow on the results.
// After the item that carries tlast, no input is taken until the run is
// delivered. The block compares one pair of stored values per cycle while it
// scans a row, through the two read ports of the value memory: with n stored
// values, a check pass of n rows finds duplicates, then a rank pass of n rows
// emits one rank per row, waiting whenever the output is stalled.
// A duplicate list ends after the check pass with one result item.
module rank_assign_with_duplicate_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] rank, [6] duplicate, [7] overflow
	output logic        m_tlast    // last_rank
);

	logic signed [rawdc_pkg::VALUE_W-1:0] mem [rawdc_pkg::CAPACITY];

	rawdc_pkg::state_t                 state_q;
	logic [rawdc_pkg::CNT_W-1:0]       cnt_q;
	logic                              ovf_q;
	logic                              mode_q;
	logic                              dup_q;
	logic [rawdc_pkg::ADDR_W-1:0]      k_q;
	logic [rawdc_pkg::ADDR_W-1:0]      i_q;
	logic [rawdc_pkg::RANK_W-1:0]      count_q;
	logic [rawdc_pkg::RANK_W-1:0]      rank_q;

	logic signed [rawdc_pkg::VALUE_W-1:0] key_s1;
	logic signed [rawdc_pkg::VALUE_W-1:0] other_s1;
	logic [rawdc_pkg::ADDR_W-1:0]         i_s1;
	logic                                 v_s1;

	logic                              out_valid_q;
	logic [rawdc_pkg::RANK_W-1:0]      out_rank_q;
	logic                              out_dup_q;
	logic                              out_ovf_q;
	logic                              out_last_q;

	logic                              in_acc;
	logic                              full;
	logic [rawdc_pkg::ADDR_W-1:0]      last_idx;
	logic                              lt;
	logic                              eq;
	logic                              dup_now;
	logic [rawdc_pkg::RANK_W-1:0]      cmp_cnt;
	logic                              out_free;
	logic                              emit_fire;

	assign s_tready  = (state_q == rawdc_pkg::ST_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (cnt_q == rawdc_pkg::CNT_W'(rawdc_pkg::CAPACITY));
	assign last_idx  = rawdc_pkg::ADDR_W'(cnt_q - rawdc_pkg::CNT_W'(1));
	assign lt        = (other_s1 < key_s1);
	assign eq        = (other_s1 == key_s1) && (i_s1 != k_q);
	assign dup_now   = dup_q || eq;
	assign cmp_cnt   = count_q + rawdc_pkg::RANK_W'(lt);
	assign out_free  = !out_valid_q || m_tready;
	assign emit_fire = out_free && ((state_q == rawdc_pkg::ST_EMIT) ||
		(state_q == rawdc_pkg::ST_EMIT_DUP));

	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			mem[cnt_q[rawdc_pkg::ADDR_W-1:0]] <= s_tdata;
		end
		key_s1   <= mem[k_q];
		other_s1 <= mem[i_q];
		i_s1     <= i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rawdc_pkg::ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			mode_q      <= 1'b0;
			dup_q       <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			count_q     <= '0;
			rank_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			out_rank_q  <= '0;
			out_dup_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == rawdc_pkg::ST_SCAN);
			if (v_s1) begin
				count_q <= (state_q == rawdc_pkg::ST_DRAIN) ? '0 : cmp_cnt;
				dup_q   <= dup_now;
			end
			unique case (state_q)
				rawdc_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + rawdc_pkg::CNT_W'(1);
						end
						if (s_tlast) begin
							mode_q  <= 1'b0;
							dup_q   <= 1'b0;
							k_q     <= '0;
							i_q     <= '0;
							count_q <= '0;
							state_q <= rawdc_pkg::ST_SCAN;
						end
					end
				end
				rawdc_pkg::ST_SCAN: begin
					if (i_q == last_idx) begin
						state_q <= rawdc_pkg::ST_DRAIN;
					end else begin
						i_q <= i_q + rawdc_pkg::ADDR_W'(1);
					end
				end
				rawdc_pkg::ST_DRAIN: begin
					i_q <= '0;
					if (mode_q) begin
						rank_q  <= cmp_cnt;
						state_q <= rawdc_pkg::ST_EMIT;
					end else if (k_q == last_idx) begin
						if (dup_now) begin
							state_q <= rawdc_pkg::ST_EMIT_DUP;
						end else begin
							mode_q  <= 1'b1;
							k_q     <= '0;
							state_q <= rawdc_pkg::ST_SCAN;
						end
					end else begin
						k_q     <= k_q + rawdc_pkg::ADDR_W'(1);
						state_q <= rawdc_pkg::ST_SCAN;
					end
				end
				rawdc_pkg::ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_rank_q  <= rank_q;
						out_dup_q   <= 1'b0;
						out_ovf_q   <= ovf_q;
						out_last_q  <= (k_q == last_idx);
						if (k_q == last_idx) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= rawdc_pkg::ST_LOAD;
						end else begin
							k_q     <= k_q + rawdc_pkg::ADDR_W'(1);
							state_q <= rawdc_pkg::ST_SCAN;
						end
					end
				end
				rawdc_pkg::ST_EMIT_DUP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_rank_q  <= '0;
						out_dup_q   <= 1'b1;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b1;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= rawdc_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= rawdc_pkg::ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ovf_q, out_dup_q, out_rank_q};
	assign m_tlast  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rawdc_pkg::CNT_W'(rawdc_pkg::CAPACITY))
		else $error("fill count beyond capacity");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rawdc_pkg::ST_SCAN) |->
		(rawdc_pkg::CNT_W'(i_q) < cnt_q) && (rawdc_pkg::CNT_W'(k_q) < cnt_q))
		else $error("scan address beyond loaded values");

	a_dup_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> (m_tlast && (m_tdata[5:0] == '0)))
		else $error("duplicate result not a single final item");

	a_drain_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rawdc_pkg::ST_DRAIN) |-> v_s1)
		else $error("row ended without a compare in flight");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams lists of signed values into the rank assignment block and checks
// every rank, duplicate, overflow and last mark against an in-bench predictor.
// Covers extreme values, single and full lists, dropped values past capacity,
// and duplicates, with random idle gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		logic [rawdc_pkg::VALUE_W-1:0] value;
		logic                          last;
	} value_item_t;

	typedef struct {
		logic [rawdc_pkg::RANK_W-1:0] rank;
		logic                         dup;
		logic                         ovf;
		logic                         fin;
	} rank_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	value_item_t pending[$];
	rank_item_t  ranks_due[$];

	logic signed [rawdc_pkg::VALUE_W-1:0] stored[rawdc_pkg::CAPACITY];
	int unsigned                          n_stored;
	logic                                 dropped;

	value_item_t next_value;
	rank_item_t  got_rank;
	rank_item_t  want_rank;
	int          s_gap, s_calm, m_wait, m_calm;
	int          errors  = 0;
	int          cycles  = 0;
	int          n_items = 0;

	rank_assign_with_duplicate_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic log_mismatch(input string what);
		if (errors < PRINT_CAP)
			$display("ERROR at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Store one value; on the last one, rank the list and queue the results.
	task automatic absorb_value(input logic [rawdc_pkg::VALUE_W-1:0] value,
		input logic last);
		logic       has_dup;
		int         smaller;
		rank_item_t r;
		if (n_stored < rawdc_pkg::CAPACITY) begin
			stored[n_stored] = value;
			n_stored++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		has_dup = 1'b0;
		for (int i = 0; i < n_stored; i++)
			for (int j = i + 1; j < n_stored; j++)
				if (stored[i] == stored[j])
					has_dup = 1'b1;
		if (has_dup) begin
			r.rank = '0;
			r.dup  = 1'b1;
			r.ovf  = dropped;
			r.fin  = 1'b1;
			ranks_due.push_back(r);
		end else begin
			for (int k = 0; k < n_stored; k++) begin
				smaller = 0;
				for (int i = 0; i < n_stored; i++)
					if (stored[i] < stored[k])
						smaller++;
				r.rank = smaller[rawdc_pkg::RANK_W-1:0];
				r.dup  = 1'b0;
				r.ovf  = dropped;
				r.fin  = (k == n_stored - 1);
				ranks_due.push_back(r);
			end
		end
		n_stored = 0;
		dropped  = 1'b0;
	endtask

	task automatic queue_value(input logic [rawdc_pkg::VALUE_W-1:0] value,
		input logic last);
		value_item_t it;
		it.value = value;
		it.last  = last;
		pending.push_back(it);
		n_items++;
	endtask

	function automatic logic [rawdc_pkg::VALUE_W-1:0] pick_value(input int narrow);
		int r;
		if (narrow)
			return $urandom_range(0, 15) - 8;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'h8000_0000;
		if (r == 1)
			return 32'h7FFF_FFFF;
		if (r < 5)
			return $urandom_range(0, 64) - 32;
		return $urandom();
	endfunction

	// kind: 0 wide random, 1 wide random with one repeated value, 2 narrow range
	task automatic queue_list(input int len, input int kind);
		logic [rawdc_pkg::VALUE_W-1:0] vals[$];
		int                            src, dst;
		for (int i = 0; i < len; i++)
			vals.push_back(pick_value(kind == 2));
		if (kind == 1 && len > 1) begin
			src = $urandom_range(0, len - 1);
			dst = $urandom_range(0, len - 1);
			if (dst == src)
				dst = (src + 1) % len;
			if (dst < rawdc_pkg::CAPACITY && src < rawdc_pkg::CAPACITY)
				vals[dst] = vals[src];
		end
		for (int i = 0; i < len; i++)
			queue_value(vals[i], i == len - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			s_gap    <= 0;
			s_calm   <= 0;
			n_stored = 0;
			dropped  = 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_value(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_tvalid <= 1'b0;
					s_gap    <= s_gap - 1;
				end else if (pending.size() > 0) begin
					next_value = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_value.value;
					s_tlast  <= next_value.last;
					if (s_calm > 0) begin
						s_calm <= s_calm - 1;
						s_gap  <= 0;
					end else if ($urandom_range(0, 19) == 0) begin
						s_calm <= $urandom_range(20, 80);
						s_gap  <= 0;
					end else begin
						s_gap <= idle_len();
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_wait   <= 0;
			m_calm   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_rank.rank = m_tdata[5:0];
				got_rank.dup  = m_tdata[6];
				got_rank.ovf  = m_tdata[7];
				got_rank.fin  = m_tlast;
				if (ranks_due.size() == 0) begin
					log_mismatch($sformatf("unexpected result rank=%0d dup=%b ovf=%b last=%b",
						got_rank.rank, got_rank.dup, got_rank.ovf, got_rank.fin));
				end else begin
					want_rank = ranks_due.pop_front();
					if (got_rank.rank !== want_rank.rank)
						log_mismatch($sformatf("rank %0d, expected %0d",
							got_rank.rank, want_rank.rank));
					if (got_rank.dup !== want_rank.dup)
						log_mismatch($sformatf("duplicate %b, expected %b",
							got_rank.dup, want_rank.dup));
					if (got_rank.ovf !== want_rank.ovf)
						log_mismatch($sformatf("overflow %b, expected %b",
							got_rank.ovf, want_rank.ovf));
					if (got_rank.fin !== want_rank.fin)
						log_mismatch($sformatf("last %b, expected %b",
							got_rank.fin, want_rank.fin));
				end
			end
			if (m_wait > 0) begin
				m_tready <= 1'b0;
				m_wait   <= m_wait - 1;
			end else if (m_calm > 0) begin
				m_tready <= 1'b1;
				m_calm   <= m_calm - 1;
			end else if ($urandom_range(0, 99) == 0) begin
				m_tready <= 1'b1;
				m_calm   <= $urandom_range(50, 300);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				m_wait   <= idle_len();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// single value
		queue_value(32'h8000_0000, 1'b1);
		// extremes and signed order
		queue_value(32'h7FFF_FFFF, 1'b0);
		queue_value(32'h8000_0000, 1'b0);
		queue_value(32'h0000_0000, 1'b0);
		queue_value(32'hFFFF_FFFF, 1'b0);
		queue_value(32'h0000_0001, 1'b1);
		// repeated value, not adjacent
		queue_value(32'd5, 1'b0);
		queue_value(-32'sd3, 1'b0);
		queue_value(32'd5, 1'b1);
		// alternating bit patterns
		queue_value(32'hAAAA_AAAA, 1'b0);
		queue_value(32'h5555_5555, 1'b1);
		// repeated extreme, adjacent
		queue_value(32'hFFFF_FFFF, 1'b0);
		queue_value(32'hFFFF_FFFF, 1'b1);
		// descending run
		queue_value(32'd3, 1'b0);
		queue_value(32'd2, 1'b0);
		queue_value(32'd1, 1'b0);
		queue_value(32'd0, 1'b0);
		queue_value(32'h8000_0001, 1'b1);

		queue_list(rawdc_pkg::CAPACITY, 0);
		queue_list(rawdc_pkg::CAPACITY + 2, 0);
		while (n_items < 420) begin
			case ($urandom_range(0, 9))
				0, 1:    queue_list($urandom_range(1, 12), 1);
				2, 3:    queue_list($urandom_range(1, 10), 2);
				4:       queue_list($urandom_range(13, 40), 0);
				default: queue_list($urandom_range(1, 12), 0);
			endcase
			if (n_items > 250 && n_items < 270)
				queue_list(rawdc_pkg::CAPACITY + 1, 1);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid || ranks_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
